// ----- rtl/ttps_pkg.sv -----
// Shared types, codes and constants of the transposition table probe/store unit.
package ttps_pkg;

  // Table geometry default
  localparam int INDEX_BITS_DEF = 16;

  // Field widths
  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 7;
  localparam int PLY_W   = 7;
  localparam int SCORE_W = 16;
  localparam int MOVE_W  = 16;

  // Mate scores lie above this magnitude
  localparam int MATE_BASE  = 30000;
  localparam int MATE_SPAN  = 256;
  localparam int MATE_LIMIT = MATE_BASE - MATE_SPAN;

  // Stream widths
  localparam int S_TDATA_W = 144;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 2;

  typedef enum logic [1:0] {
    OP_PROBE = 2'd0,
    OP_STORE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    BND_EMPTY = 2'd0,
    BND_EXACT = 2'd1,
    BND_LOWER = 2'd2,
    BND_UPPER = 2'd3
  } bound_e;

  // One accepted request
  typedef struct packed {
    op_e                       op;
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic [PLY_W-1:0]          ply;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;
    logic signed [SCORE_W-1:0] score;
    logic [MOVE_W-1:0]         move;
  } item_t;

  // One table entry as held in the memory
  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    bound_e                    bound;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One response
  typedef struct packed {
    logic                      hit;
    logic                      cutoff;
    logic signed [SCORE_W-1:0] score;
    logic [MOVE_W-1:0]         move;
  } result_t;

endpackage

// ----- rtl/ttps_mem.sv -----
// Single-port-write, single-port-read entry memory with registered read data.
module ttps_mem #(
  parameter int ADDR_W = ttps_pkg::INDEX_BITS_DEF,
  parameter int DATA_W = ttps_pkg::ENTRY_W
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] ram_q [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_q;

  // Write port, then registered read; read data holds when not enabled
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ram_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= ram_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/ttps_eval.sv -----
// Probe evaluation and store entry formation for one request against one entry.
module ttps_eval (
  input  ttps_pkg::item_t   item_i,
  input  ttps_pkg::entry_t  rd_entry_i,
  output ttps_pkg::result_t result_o,
  output ttps_pkg::entry_t  wr_entry_o
);

  localparam logic signed [16:0] MATE_HI = 17'(ttps_pkg::MATE_LIMIT);
  localparam logic signed [16:0] MATE_LO = -MATE_HI;
  localparam logic signed [16:0] SAT_HI  = 17'sd32767;
  localparam logic signed [16:0] SAT_LO  = -17'sd32768;

  logic signed [16:0] ply_s, alpha_s, beta_s, in_score_s, ent_score_s;
  logic signed [16:0] pr_adj, st_adj;
  logic signed [15:0] st_sat;
  logic               pr_hit, pr_deep, pr_cut;
  ttps_pkg::bound_e   st_kind;

  // Widen operands to 17 bits so shifts and compares cannot wrap
  assign ply_s       = signed'({10'd0, item_i.ply});
  assign alpha_s     = signed'({item_i.alpha[15], item_i.alpha});
  assign beta_s      = signed'({item_i.beta[15], item_i.beta});
  assign in_score_s  = signed'({item_i.score[15], item_i.score});
  assign ent_score_s = signed'({rd_entry_i.score[15], rd_entry_i.score});

  // Probe: match, depth check, undo the mate shift, bound test
  always_comb begin
    pr_hit  = (item_i.ply != '0) && (rd_entry_i.key == item_i.key) &&
              (rd_entry_i.bound != ttps_pkg::BND_EMPTY);
    pr_deep = rd_entry_i.depth >= item_i.depth;
    if (ent_score_s > MATE_HI) begin
      pr_adj = ent_score_s - ply_s;
    end else if (ent_score_s < MATE_LO) begin
      pr_adj = ent_score_s + ply_s;
    end else begin
      pr_adj = ent_score_s;
    end
    pr_cut = pr_hit && pr_deep &&
             ((rd_entry_i.bound == ttps_pkg::BND_EXACT) ||
              ((rd_entry_i.bound == ttps_pkg::BND_LOWER) && (pr_adj >= beta_s)) ||
              ((rd_entry_i.bound == ttps_pkg::BND_UPPER) && (pr_adj <= alpha_s)));
  end

  // Store: bound kind from the original window, mate shift with saturation
  always_comb begin
    if (in_score_s <= alpha_s) begin
      st_kind = ttps_pkg::BND_UPPER;
    end else if (in_score_s >= beta_s) begin
      st_kind = ttps_pkg::BND_LOWER;
    end else begin
      st_kind = ttps_pkg::BND_EXACT;
    end
    if (in_score_s > MATE_HI) begin
      st_adj = in_score_s + ply_s;
    end else if (in_score_s < MATE_LO) begin
      st_adj = in_score_s - ply_s;
    end else begin
      st_adj = in_score_s;
    end
    if (st_adj > SAT_HI) begin
      st_sat = 16'sh7FFF;
    end else if (st_adj < SAT_LO) begin
      st_sat = 16'sh8000;
    end else begin
      st_sat = st_adj[15:0];
    end
  end

  // Only a probe gives a non-zero response
  always_comb begin
    result_o = '0;
    if (item_i.op == ttps_pkg::OP_PROBE) begin
      result_o.hit    = pr_hit;
      result_o.cutoff = pr_cut;
      result_o.score  = pr_cut ? pr_adj[15:0] : 16'sd0;
      result_o.move   = pr_hit ? rd_entry_i.move : '0;
    end
  end

  assign wr_entry_o.key   = item_i.key;
  assign wr_entry_o.move  = item_i.move;
  assign wr_entry_o.score = st_sat;
  assign wr_entry_o.depth = item_i.depth;
  assign wr_entry_o.bound = st_kind;

endmodule

// ----- rtl/transposition_table_probe_store_unit.sv -----
// Top level: direct-mapped always-replace transposition table with stream ports.
//
//   channel   direction  tdata (low bit up)                          tuser
//   s_axis    in         key, depth, ply, alpha, beta, score, move   operation
//   m_axis    out        found_score, found_move                     hit, cutoff
//
// A probe or store is accepted in ST_IDLE, which issues the entry read; ST_EXEC
// then evaluates the read data and writes the entry back (store).
// A clear answers with an all-zero response from ST_EXEC, then sweeps all
// 2**INDEX_BITS entries, one entry per cycle through the single write port,
// with s_axis_tready low. After reset the same sweep runs before the first beat.
// A full output register stalls ST_EXEC until m_axis_tready.
module transposition_table_probe_store_unit #(
  parameter int INDEX_BITS = ttps_pkg::INDEX_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // key[63:0], depth[70:64], ply[77:71], alpha[93:78], beta[109:94],
  // score[125:110], move[141:126], zero[143:142]
  input  logic [ttps_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // operation[1:0]
  input  logic [ttps_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // found_score[15:0], found_move[31:16]
  output logic [ttps_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // hit[0], cutoff[1]
  output logic [ttps_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                          state_q, state_d;
  logic [INDEX_BITS-1:0]           ptr_q, ptr_d;
  logic                            out_valid_q, out_valid_d;
  ttps_pkg::result_t               out_q, out_d;
  ttps_pkg::item_t                 item_q, item_d, in_item;
  ttps_pkg::entry_t                rd_entry, wr_entry;
  ttps_pkg::result_t               result;
  logic [ttps_pkg::ENTRY_W-1:0]    rd_data, wr_data;
  logic [INDEX_BITS-1:0]           wr_addr;
  logic                            wr_en, accept, out_free;

  // Unpack the input beat
  assign in_item.op    = ttps_pkg::op_e'(s_axis_tuser[1:0]);
  assign in_item.key   = s_axis_tdata[63:0];
  assign in_item.depth = s_axis_tdata[70:64];
  assign in_item.ply   = s_axis_tdata[77:71];
  assign in_item.alpha = s_axis_tdata[93:78];
  assign in_item.beta  = s_axis_tdata[109:94];
  assign in_item.score = s_axis_tdata[125:110];
  assign in_item.move  = s_axis_tdata[141:126];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  ttps_mem #(
    .ADDR_W (INDEX_BITS),
    .DATA_W (ttps_pkg::ENTRY_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (in_item.key[INDEX_BITS-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign rd_entry = ttps_pkg::entry_t'(rd_data);

  ttps_eval u_eval (
    .item_i     (item_q),
    .rd_entry_i (rd_entry),
    .result_o   (result),
    .wr_entry_o (wr_entry)
  );

  // Sequence sweep, accept and evaluate; drain the output register on tready
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    item_d      = item_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    wr_en       = 1'b0;
    wr_addr     = item_q.key[INDEX_BITS-1:0];
    wr_data     = wr_entry;
    unique case (state_q)
      ST_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = ptr_q;
        wr_data = '0;
        ptr_d   = ptr_q + 1'b1;
        if (&ptr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          item_d  = in_item;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_d       = result;
          out_valid_d = 1'b1;
          wr_en       = (item_q.op == ttps_pkg::OP_STORE);
          if (item_q.op == ttps_pkg::OP_CLEAR) begin
            ptr_d   = '0;
            state_d = ST_SWEEP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state, sweep pointer and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.move, out_q.score};
  assign m_axis_tuser  = {out_q.cutoff, out_q.hit};

endmodule

// ----- rtl/ttps_checker.sv -----
// Port-level checks of the transposition table unit, bound to its top level.
module ttps_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ttps_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [ttps_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  // Keep a stalled beat in place
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // A cutoff needs a hit
  a_cut_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("cutoff without hit");

  // A miss returns an all-zero payload
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("miss with non-zero payload");

  // Without a cutoff the score is zero
  a_nocut_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[15:0] == 16'd0)
    else $error("score without cutoff");

endmodule

bind transposition_table_probe_store_unit ttps_checker u_ttps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
